[src/bech_pkg.sv]
`default_nettype none

package bech_pkg;

  localparam logic [6:0]  CharCountSat   = 7'd127;
  localparam logic [6:0]  MinChars       = 7'd6;
  localparam logic [6:0]  MinDataSymbols = 7'd7;
  localparam logic [6:0]  ResultByteLimit = 7'd51;
  localparam logic [5:0]  BadSymbol      = 6'd32;
  localparam logic [7:0]  DelimChar      = 8'h31;
  localparam logic [7:0]  QChar          = 8'h71;
  localparam logic [7:0]  VersionBase    = 8'd80;
  localparam logic [4:0]  MaxVersion     = 5'd16;
  localparam logic [3:0]  ByteBits       = 4'd8;
  localparam logic [3:0]  SymBits        = 4'd5;
  localparam logic [29:0] ChecksumInit   = 30'h1;
  localparam logic [29:0] TargetBech32   = 30'h1;
  localparam logic [29:0] TargetBech32m  = 30'h2bc830a3;

  localparam logic [29:0] PolyGen [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  typedef struct packed {
    logic take;
    logic replay;
    logic emit;
  } bech_cmd_t;

  typedef struct packed {
    logic start_replay;
    logic replay_last;
    logic emit_done;
  } bech_sts_t;

  function automatic logic [29:0] polymod_step(input logic [29:0] chk, input logic [4:0] sym);
    logic [29:0] r;
    r = {chk[24:0], sym};
    for (int k = 0; k < 5; k++) begin
      if (chk[25+k]) begin
        r = r ^ PolyGen[k];
      end
    end
    return r;
  endfunction

  function automatic logic [5:0] charset_lookup(input logic [6:0] c);
    logic [6:0] key;
    key = (c >= 7'h60) ? (c - 7'h20) : c;
    unique case (key)
      7'h30:   return 6'd15;
      7'h32:   return 6'd10;
      7'h33:   return 6'd17;
      7'h34:   return 6'd21;
      7'h35:   return 6'd20;
      7'h36:   return 6'd26;
      7'h37:   return 6'd30;
      7'h38:   return 6'd7;
      7'h39:   return 6'd5;
      7'h41:   return 6'd29;
      7'h43:   return 6'd24;
      7'h44:   return 6'd13;
      7'h45:   return 6'd25;
      7'h46:   return 6'd9;
      7'h47:   return 6'd8;
      7'h48:   return 6'd23;
      7'h4a:   return 6'd18;
      7'h4b:   return 6'd22;
      7'h4c:   return 6'd31;
      7'h4d:   return 6'd27;
      7'h4e:   return 6'd19;
      7'h50:   return 6'd1;
      7'h51:   return 6'd0;
      7'h52:   return 6'd3;
      7'h53:   return 6'd16;
      7'h54:   return 6'd11;
      7'h55:   return 6'd28;
      7'h56:   return 6'd12;
      7'h57:   return 6'd14;
      7'h58:   return 6'd6;
      7'h59:   return 6'd4;
      7'h5a:   return 6'd2;
      default: return BadSymbol;
    endcase
  endfunction

endpackage

`default_nettype wire

[src/bech_if.sv]
`default_nettype none

interface bech_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       final_char;

  modport source(output valid, output char_code, output final_char, input ready);
  modport sink(input valid, input char_code, input final_char, output ready);
endinterface

interface bech_script_if;
  logic       valid;
  logic       ready;
  logic [7:0] script_byte;
  logic       accepted;
  logic       run_end;

  modport source(output valid, output script_byte, output accepted, output run_end, input ready);
  modport sink(input valid, input script_byte, input accepted, input run_end, output ready);
endinterface

`default_nettype wire

[src/bech32_address_decoder_unit.sv]
// Streaming bech32/bech32m segwit address decoder.
// char_i takes one ASCII character per transfer, final_char set on the last one
// of an address. script_o returns the decoded script: version opcode, program
// length, then the program bytes, accepted set on each and run_end on the last.
// A rejected address yields a single result with byte zero, accepted clear and
// run_end set.
// Throughput: one character per cycle while char_i is ready. After the
// delimiter, the shared checksum step replays the buffered low parts from the
// prefix memory. After the final character, results follow at one per cycle
// while script_o is ready (one output register, program bytes read ahead from
// the program memory). char_i is not ready during replay and result emission;
// it is ready again in the cycle after the last result enters the output
// register, while that result may still wait. A stalled receiver holds the
// output register and emission pauses. Reset clears the address registers
// except the symbol delay line and prefix memory, and drops any pending result.
`default_nettype none

module bech32_address_decoder_unit
  import bech_pkg::*;
#(
  parameter int unsigned MAX_ADDRESS_CHARS = 90,
  parameter int unsigned PROGRAM_DEPTH     = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bech_char_if.sink   char_i,
  bech_script_if.source script_o
);

  bech_cmd_t cmd;
  bech_sts_t sts;

  bech_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (char_i.valid),
    .in_final_i (char_i.final_char),
    .in_ready_o (char_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bech_dp #(
    .MAX_ADDRESS_CHARS (MAX_ADDRESS_CHARS),
    .PROGRAM_DEPTH     (PROGRAM_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .char_code_i   (char_i.char_code),
    .sts_o         (sts),
    .out_valid_o   (script_o.valid),
    .out_ready_i   (script_o.ready),
    .script_byte_o (script_o.script_byte),
    .accepted_o    (script_o.accepted),
    .run_end_o     (script_o.run_end)
  );

endmodule

`default_nettype wire

[src/bech_ctrl.sv]
`default_nettype none

module bech_ctrl
  import bech_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_final_i,
  output logic      in_ready_o,
  output bech_cmd_t cmd_o,
  input  bech_sts_t sts_i
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StReplay = 2'd1;
  localparam logic [1:0] StEmit   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       fin_q, fin_d;

  assign in_ready_o   = (state_q == StIdle);
  assign cmd_o.take   = (state_q == StIdle) && in_valid_i;
  assign cmd_o.replay = (state_q == StReplay);
  assign cmd_o.emit   = (state_q == StEmit);

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          fin_d = in_final_i;
          if (sts_i.start_replay) begin
            state_d = StReplay;
          end else if (in_final_i) begin
            state_d = StEmit;
          end
        end
      end
      StReplay: begin
        if (sts_i.replay_last) begin
          state_d = fin_q ? StEmit : StIdle;
        end
      end
      StEmit: begin
        if (sts_i.emit_done) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

endmodule

`default_nettype wire

[src/bech_dp.sv]
`default_nettype none

module bech_dp
  import bech_pkg::*;
#(
  parameter int unsigned MAX_ADDRESS_CHARS = 90,
  parameter int unsigned PROGRAM_DEPTH     = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bech_cmd_t  cmd_i,
  input  logic [7:0] char_code_i,
  output bech_sts_t  sts_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] script_byte_o,
  output logic       accepted_o,
  output logic       run_end_o
);

  localparam int unsigned PW        = $clog2(PROGRAM_DEPTH);
  localparam logic [6:0]  MaxChars  = 7'(MAX_ADDRESS_CHARS);
  localparam logic [7:0]  ProgDepth = 8'(PROGRAM_DEPTH);

  logic [4:0]  prefix_mem [128];
  logic [7:0]  prog_mem   [PROGRAM_DEPTH];

  logic [6:0]  cc_q, cc_d;
  logic        delim_q, delim_d;
  logic [29:0] csum_q, csum_d;
  logic [4:0]  dly_q [6];
  logic [4:0]  dly_d [6];
  logic [6:0]  dsc_q, dsc_d;
  logic [4:0]  ver_q, ver_d;
  logic        firstq_q, firstq_d;
  logic [11:0] acc_q, acc_d;
  logic [3:0]  bits_q, bits_d;
  logic [6:0]  plen_q, plen_d;
  logic        err_q, err_d;
  logic [6:0]  rep_len_q, rep_len_d;
  logic [6:0]  rep_idx_q, rep_idx_d;
  logic [6:0]  em_idx_q, em_idx_d;
  logic [4:0]  pre_rd_q;
  logic [7:0]  prog_rd_q;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_acc_q, out_acc_d;
  logic        out_end_q, out_end_d;

  logic        err_n;
  logic [5:0]  sym;
  logic [11:0] acc_n;
  logic [3:0]  bits_n;
  logic [3:0]  byte_sh;
  logic        feed_en;
  logic [4:0]  feed_val;
  logic        pre_we;
  logic        prog_we;
  logic [7:0]  prog_wdata;
  logic [6:0]  pre_raddr;
  logic [6:0]  prog_raddr;
  logic        ok;
  logic        out_free;
  logic        em_adv;
  logic        em_last;
  logic        done;
  logic [29:0] target;
  logic [7:0]  pad_mask;

  assign target   = firstq_q ? TargetBech32 : TargetBech32m;
  assign pad_mask = 8'((9'd1 << bits_q) - 9'd1);
  assign ok = !err_q && (cc_q >= MinChars) && (cc_q <= MaxChars) && delim_q
           && (dsc_q >= MinDataSymbols) && (csum_q == target) && (bits_q < SymBits)
           && ((acc_q[7:0] & pad_mask) == 8'd0) && (plen_q != 7'd0)
           && (ver_q <= MaxVersion);
  assign out_free = !out_valid_q || out_ready_i;
  assign em_adv   = cmd_i.emit && out_free;
  assign em_last  = (em_idx_q == (plen_q + 7'd1));

  assign pre_raddr  = cmd_i.replay ? (rep_idx_q + 7'd1) : 7'd0;
  assign prog_raddr = em_adv ? (em_idx_q - 7'd1) : (em_idx_q - 7'd2);

  always_comb begin
    cc_d        = cc_q;
    delim_d     = delim_q;
    csum_d      = csum_q;
    dly_d       = dly_q;
    dsc_d       = dsc_q;
    ver_d       = ver_q;
    firstq_d    = firstq_q;
    acc_d       = acc_q;
    bits_d      = bits_q;
    plen_d      = plen_q;
    err_d       = err_q;
    rep_len_d   = rep_len_q;
    rep_idx_d   = rep_idx_q;
    em_idx_d    = em_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_acc_d   = out_acc_q;
    out_end_d   = out_end_q;
    err_n       = 1'b0;
    sym         = charset_lookup(char_code_i[6:0]);
    acc_n       = {acc_q[6:0], dly_q[0]};
    bits_n      = bits_q + SymBits;
    byte_sh     = bits_n - ByteBits;
    feed_en     = 1'b0;
    feed_val    = 5'd0;
    pre_we      = 1'b0;
    prog_we     = 1'b0;
    prog_wdata  = 8'(acc_n >> byte_sh);
    sts_o       = '0;
    done        = 1'b0;

    if (cmd_i.take) begin
      cc_d  = (cc_q == CharCountSat) ? cc_q : (cc_q + 7'd1);
      err_n = err_q || (cc_q >= MaxChars) || char_code_i[7];
      err_d = err_n;
      if (!err_n) begin
        if (!delim_q) begin
          if (char_code_i == DelimChar) begin
            delim_d            = 1'b1;
            feed_en            = 1'b1;
            rep_len_d          = cc_q;
            rep_idx_d          = 7'd0;
            sts_o.start_replay = (cc_q != 7'd0);
          end else begin
            feed_en  = 1'b1;
            feed_val = {2'b00, char_code_i[7:5]};
            pre_we   = 1'b1;
          end
        end else if (sym == BadSymbol) begin
          err_d = 1'b1;
        end else begin
          feed_en  = 1'b1;
          feed_val = sym[4:0];
          if (dsc_q == 7'd0) begin
            ver_d    = sym[4:0];
            firstq_d = (char_code_i == QChar);
          end else begin
            for (int i = 0; i < 5; i++) begin
              dly_d[i] = dly_q[i+1];
            end
            dly_d[5] = sym[4:0];
            if (dsc_q >= MinDataSymbols) begin
              acc_d  = acc_n;
              bits_d = bits_n;
              if (bits_n >= ByteBits) begin
                bits_d = byte_sh;
                if (({1'b0, plen_q} >= ProgDepth) || (plen_q >= ResultByteLimit)) begin
                  err_d = 1'b1;
                end else begin
                  prog_we = 1'b1;
                  plen_d  = plen_q + 7'd1;
                end
              end
            end
          end
          dsc_d = (dsc_q == CharCountSat) ? dsc_q : (dsc_q + 7'd1);
        end
      end
    end

    if (cmd_i.replay) begin
      feed_en           = 1'b1;
      feed_val          = pre_rd_q;
      rep_idx_d         = rep_idx_q + 7'd1;
      sts_o.replay_last = ((rep_idx_q + 7'd1) == rep_len_q);
    end

    if (feed_en) begin
      csum_d = polymod_step(csum_q, feed_val);
    end

    if (em_adv) begin
      out_valid_d = 1'b1;
      em_idx_d    = em_idx_q + 7'd1;
      if ((em_idx_q == 7'd0) && !ok) begin
        out_byte_d = 8'd0;
        out_acc_d  = 1'b0;
        out_end_d  = 1'b1;
        done       = 1'b1;
      end else begin
        if (em_idx_q == 7'd0) begin
          out_byte_d = (ver_q == 5'd0) ? 8'd0 : (VersionBase + {3'b000, ver_q});
        end else if (em_idx_q == 7'd1) begin
          out_byte_d = {1'b0, plen_q};
        end else begin
          out_byte_d = prog_rd_q;
        end
        out_acc_d = 1'b1;
        out_end_d = em_last;
        done      = em_last;
      end
    end

    if (done) begin
      cc_d     = 7'd0;
      delim_d  = 1'b0;
      csum_d   = ChecksumInit;
      dsc_d    = 7'd0;
      ver_d    = 5'd0;
      firstq_d = 1'b0;
      acc_d    = 12'd0;
      bits_d   = 4'd0;
      plen_d   = 7'd0;
      err_d    = 1'b0;
      em_idx_d = 7'd0;
    end
    sts_o.emit_done = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q        <= 7'd0;
      delim_q     <= 1'b0;
      csum_q      <= ChecksumInit;
      dsc_q       <= 7'd0;
      ver_q       <= 5'd0;
      firstq_q    <= 1'b0;
      acc_q       <= 12'd0;
      bits_q      <= 4'd0;
      plen_q      <= 7'd0;
      err_q       <= 1'b0;
      rep_len_q   <= 7'd0;
      rep_idx_q   <= 7'd0;
      em_idx_q    <= 7'd0;
      out_valid_q <= 1'b0;
    end else begin
      cc_q        <= cc_d;
      delim_q     <= delim_d;
      csum_q      <= csum_d;
      dsc_q       <= dsc_d;
      ver_q       <= ver_d;
      firstq_q    <= firstq_d;
      acc_q       <= acc_d;
      bits_q      <= bits_d;
      plen_q      <= plen_d;
      err_q       <= err_d;
      rep_len_q   <= rep_len_d;
      rep_idx_q   <= rep_idx_d;
      em_idx_q    <= em_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dly_q      <= dly_d;
    out_byte_q <= out_byte_d;
    out_acc_q  <= out_acc_d;
    out_end_q  <= out_end_d;
  end

  always_ff @(posedge clk_i) begin
    if (pre_we) begin
      prefix_mem[cc_q] <= char_code_i[4:0];
    end
    pre_rd_q <= prefix_mem[pre_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (prog_we) begin
      prog_mem[plen_q[PW-1:0]] <= prog_wdata;
    end
    prog_rd_q <= prog_mem[prog_raddr[PW-1:0]];
  end

  assign out_valid_o   = out_valid_q;
  assign script_byte_o = out_byte_q;
  assign accepted_o    = out_acc_q;
  assign run_end_o     = out_end_q;

endmodule

`default_nettype wire

[src/bech_chk.sv]
`default_nettype none

module bech_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_final_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_accepted_i,
  input logic       out_end_i
);

  a_reject_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_accepted_i) |-> (out_end_i && (out_byte_i == 8'd0)))
    else $error("rejected result is not a lone zero result");

  a_no_input_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_end_i) |-> !in_ready_i)
    else $error("input ready while a script is still being emitted");

  a_no_result_midaddr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !in_final_i)
      |=> (!out_valid_i || $past(out_valid_i && !out_ready_i)))
    else $error("new result after a non-final character");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i)
      |=> (out_valid_i && $stable(out_byte_i) && $stable(out_end_i)))
    else $error("stalled result changed");

endmodule

bind bech32_address_decoder_unit bech_chk u_bech_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (char_i.valid),
  .in_ready_i     (char_i.ready),
  .in_final_i     (char_i.final_char),
  .out_valid_i    (script_o.valid),
  .out_ready_i    (script_o.ready),
  .out_byte_i     (script_o.script_byte),
  .out_accepted_i (script_o.accepted),
  .out_end_i      (script_o.run_end)
);

`default_nettype wire

[verif/testbench.sv]
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]  DELIM_CHAR    = 8'h31;
  localparam logic [7:0]  Q_CHAR        = 8'h71;
  localparam int          MAX_CHARS     = 90;
  localparam int          PROG_DEPTH    = 64;
  localparam int          PROG_LIMIT    = 51;
  localparam int          COUNT_SAT     = 127;
  localparam logic [7:0]  VERSION_BASE  = 8'd80;
  localparam int          MAX_VERSION   = 16;
  localparam logic [29:0] BECH32_CONST  = 30'h1;
  localparam logic [29:0] BECH32M_CONST = 30'h2bc830a3;
  localparam logic [29:0] GEN0 = 30'h3b6a57b2;
  localparam logic [29:0] GEN1 = 30'h26508e6d;
  localparam logic [29:0] GEN2 = 30'h1ea119fa;
  localparam logic [29:0] GEN3 = 30'h3d4233dd;
  localparam logic [29:0] GEN4 = 30'h2a1462b3;
  localparam logic [8*32-1:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [7:0] sbyte;
    logic       accepted;
    logic       run_end;
  } script_res_t;

  logic clk_i;
  logic rst_ni;

  bech_char_if   char_bus ();
  bech_script_if script_bus ();

  bech32_address_decoder_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_bus),
    .script_o(script_bus)
  );

  script_res_t pending_script[$];
  int          error_count;
  bit          idle_on;
  bit          hold_request;

  logic [7:0] hrp[$];
  logic [4:0] data_syms[$];
  logic [7:0] addr_chars[$];

  int         m_count;
  bit         m_delim;
  logic [4:0] m_prefix[128];
  logic [29:0] m_chk;
  logic [4:0] m_delay[6];
  int         m_dsyms;
  logic [4:0] m_ver;
  bit         m_first_q;
  int         m_racc;
  int         m_rbits;
  logic [7:0] m_prog[PROG_DEPTH];
  int         m_plen;
  bit         m_err;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [29:0] chk_advance(input logic [29:0] chk, input logic [4:0] v);
    logic [29:0] r;
    r = {chk[24:0], v};
    if (chk[25]) r = r ^ GEN0;
    if (chk[26]) r = r ^ GEN1;
    if (chk[27]) r = r ^ GEN2;
    if (chk[28]) r = r ^ GEN3;
    if (chk[29]) r = r ^ GEN4;
    return r;
  endfunction

  function automatic logic [7:0] sym_char(input logic [4:0] sym, input bit upper);
    logic [7:0] c;
    c = ALPHABET[8*(31-sym) +: 8];
    if (upper && c >= "a" && c <= "z") c = c - 8'd32;
    return c;
  endfunction

  // 32 flags a character outside the charset
  function automatic logic [5:0] symbol_value(input logic [6:0] c7);
    logic [7:0] c;
    int k;
    c = {1'b0, c7};
    if (c >= "A" && c <= "Z") c = c + 8'd32;
    for (k = 0; k < 32; k++) begin
      if (ALPHABET[8*(31-k) +: 8] == c) return 6'(k);
    end
    return 6'd32;
  endfunction

  function automatic int idle_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic clear_decoder();
    int i;
    m_count = 0;
    m_delim = 0;
    for (i = 0; i < 128; i++) m_prefix[i] = '0;
    m_chk = 30'h1;
    for (i = 0; i < 6; i++) m_delay[i] = '0;
    m_dsyms = 0;
    m_ver = '0;
    m_first_q = 0;
    m_racc = 0;
    m_rbits = 0;
    for (i = 0; i < PROG_DEPTH; i++) m_prog[i] = '0;
    m_plen = 0;
    m_err = 0;
  endtask

  task automatic regroup_symbol(input logic [4:0] sym);
    m_racc = ((m_racc << 5) | int'(sym)) & 'hfff;
    m_rbits += 5;
    if (m_rbits >= 8) begin
      m_rbits -= 8;
      if (m_plen >= PROG_DEPTH || m_plen >= PROG_LIMIT) begin
        m_err = 1;
        return;
      end
      m_prog[m_plen] = 8'((m_racc >> m_rbits) & 'hff);
      m_plen++;
    end
  endtask

  task automatic absorb_char(input logic [7:0] c);
    int pos;
    int i;
    logic [5:0] d;
    logic [4:0] leaving;
    pos = m_count;
    if (m_count >= MAX_CHARS) m_err = 1;
    if (m_count < COUNT_SAT) m_count++;
    if (c[7]) m_err = 1;
    if (m_err) return;
    if (!m_delim) begin
      if (c == DELIM_CHAR) begin
        m_delim = 1;
        m_chk = chk_advance(m_chk, 5'd0);
        for (i = 0; i < pos; i++) m_chk = chk_advance(m_chk, m_prefix[i]);
      end else begin
        m_chk = chk_advance(m_chk, {2'b00, c[7:5]});
        m_prefix[pos] = c[4:0];
      end
      return;
    end
    d = symbol_value(c[6:0]);
    if (d[5]) begin
      m_err = 1;
      return;
    end
    m_chk = chk_advance(m_chk, d[4:0]);
    if (m_dsyms == 0) begin
      m_ver = d[4:0];
      m_first_q = (c == Q_CHAR);
    end else begin
      leaving = m_delay[0];
      for (i = 0; i < 5; i++) m_delay[i] = m_delay[i+1];
      m_delay[5] = d[4:0];
      if (m_dsyms >= 7) regroup_symbol(leaving);
    end
    if (m_dsyms < COUNT_SAT) m_dsyms++;
  endtask

  task automatic decode_char(input logic [7:0] c, input logic fin);
    logic [29:0] target;
    bit ok;
    int n;
    int k;
    script_res_t r;
    absorb_char(c);
    if (!fin) return;
    target = m_first_q ? BECH32_CONST : BECH32M_CONST;
    ok = !m_err && m_count >= 6 && m_count <= MAX_CHARS && m_delim && m_dsyms >= 7
         && m_chk == target && m_rbits < 5 && ((m_racc << (8 - m_rbits)) & 'hff) == 0
         && m_plen > 0 && int'(m_ver) <= MAX_VERSION;
    if (!ok) begin
      r.sbyte = 8'd0;
      r.accepted = 1'b0;
      r.run_end = 1'b1;
      pending_script.insert(pending_script.size(), r);
    end else begin
      n = m_plen + 2;
      for (k = 0; k < n; k++) begin
        if (k == 0) r.sbyte = (m_ver == 0) ? 8'd0 : VERSION_BASE + 8'(m_ver);
        else if (k == 1) r.sbyte = 8'(m_plen);
        else r.sbyte = m_prog[k-2];
        r.accepted = 1'b1;
        r.run_end = (k + 1 == n);
        pending_script.insert(pending_script.size(), r);
      end
    end
    clear_decoder();
  endtask

  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      char_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_bus.valid      <= 1'b1;
    char_bus.char_code  <= c;
    char_bus.final_char <= fin;
    @(posedge clk_i);
    while (!char_bus.ready) @(posedge clk_i);
    decode_char(c, fin);
  endtask

  task automatic send_address();
    int i;
    for (i = 0; i < addr_chars.size(); i++) begin
      send_char(addr_chars[i], i == addr_chars.size() - 1);
    end
  endtask

  task automatic make_hrp(input int n);
    int i;
    logic [7:0] c;
    hrp.delete();
    for (i = 0; i < n; i++) begin
      do c = 8'($urandom_range(0, 127)); while (c == DELIM_CHAR);
      hrp.insert(hrp.size(), c);
    end
  endtask

  task automatic add_program(input int nbytes, input bit dirty_pad);
    int acc;
    int bits;
    int k;
    logic [4:0] last;
    acc = 0;
    bits = 0;
    for (k = 0; k < nbytes; k++) begin
      acc = ((acc << 8) | int'($urandom_range(0, 255))) & 'hfff;
      bits += 8;
      while (bits >= 5) begin
        bits -= 5;
        data_syms.insert(data_syms.size(), 5'((acc >> bits) & 31));
      end
    end
    if (bits > 0) begin
      last = 5'((acc << (5 - bits)) & 31);
      if (dirty_pad) last[0] = 1'b1;
      data_syms.insert(data_syms.size(), last);
    end else if (dirty_pad) begin
      data_syms.insert(data_syms.size(), 5'($urandom_range(0, 31)));
    end
  endtask

  function automatic bit pick_upper(input int case_mode);
    return case_mode == 1 || (case_mode == 2 && $urandom_range(0, 1) == 1);
  endfunction

  // version below zero omits the version symbol; with nbytes zero too the data part holds checksum symbols only
  task automatic compose_address(input int ver, input int nbytes, input int case_mode,
                                 input bit dirty_pad, input bit flip_target);
    logic [29:0] chk;
    logic [29:0] target;
    logic [7:0] data_chars[$];
    int i;
    data_syms.delete();
    addr_chars.delete();
    if (ver >= 0) data_syms.insert(data_syms.size(), 5'(ver));
    add_program(nbytes, dirty_pad);
    chk = 30'h1;
    for (i = 0; i < hrp.size(); i++) chk = chk_advance(chk, {2'b00, hrp[i][7:5]});
    chk = chk_advance(chk, 5'd0);
    for (i = 0; i < hrp.size(); i++) chk = chk_advance(chk, hrp[i][4:0]);
    for (i = 0; i < data_syms.size(); i++) chk = chk_advance(chk, data_syms[i]);
    for (i = 0; i < 6; i++) chk = chk_advance(chk, 5'd0);
    for (i = 0; i < data_syms.size(); i++) begin
      data_chars.insert(data_chars.size(), sym_char(data_syms[i], pick_upper(case_mode)));
    end
    target = (data_chars.size() > 0 && data_chars[0] == Q_CHAR) ? BECH32_CONST : BECH32M_CONST;
    if (flip_target) target = target ^ BECH32_CONST ^ BECH32M_CONST;
    chk = chk ^ target;
    for (i = 0; i < hrp.size(); i++) addr_chars.insert(addr_chars.size(), hrp[i]);
    addr_chars.insert(addr_chars.size(), DELIM_CHAR);
    for (i = 0; i < data_chars.size(); i++) addr_chars.insert(addr_chars.size(), data_chars[i]);
    for (i = 0; i < 6; i++) begin
      addr_chars.insert(addr_chars.size(), sym_char(chk[5*(5-i) +: 5], pick_upper(case_mode)));
    end
  endtask

  task automatic fill_random_chars(input int n, input int top);
    int i;
    addr_chars.delete();
    for (i = 0; i < n; i++) addr_chars.insert(addr_chars.size(), 8'($urandom_range(0, top)));
  endtask

  task automatic mangle_address();
    int pos;
    pos = $urandom_range(0, addr_chars.size() - 1);
    case ($urandom_range(0, 4))
      0: addr_chars[pos] = 8'($urandom_range(0, 255));
      1: addr_chars[pos] = 8'($urandom_range(0, 127));
      2: if (addr_chars.size() > 1) addr_chars.delete(pos);
      3: addr_chars.insert(pos, 8'($urandom_range(0, 255)));
      default: while (addr_chars.size() > pos + 1) void'(addr_chars.pop_back());
    endcase
  endtask

  task automatic test_segwit_basics();
    idle_on = 0;
    hrp.delete();
    hrp.insert(hrp.size(), "b");
    hrp.insert(hrp.size(), "c");
    compose_address(0, 20, 0, 0, 0);
    send_address();
    hrp.delete();
    hrp.insert(hrp.size(), "t");
    hrp.insert(hrp.size(), "b");
    compose_address(0, 32, 1, 0, 0);
    send_address();
    idle_on = 1;
    make_hrp(3);
    compose_address(1, 32, 0, 0, 0);
    send_address();
    make_hrp(2);
    compose_address(MAX_VERSION, 2, 2, 0, 0);
    send_address();
    hrp.delete();
    compose_address(0, PROG_LIMIT, 2, 0, 0);
    send_address();
    hrp.delete();
    hrp.insert(hrp.size(), 8'h00);
    hrp.insert(hrp.size(), 8'h7f);
    compose_address(0, 1, 0, 0, 0);
    send_address();
  endtask

  task automatic test_version_range();
    make_hrp(2);
    compose_address(MAX_VERSION + 1, 4, 0, 0, 0);
    send_address();
    make_hrp(2);
    compose_address(31, 4, 1, 0, 0);
    send_address();
  endtask

  task automatic test_bad_characters();
    make_hrp(3);
    hrp[1] = 8'hff;
    compose_address(0, 20, 0, 0, 0);
    send_address();
    make_hrp(2);
    compose_address(0, 20, 0, 0, 0);
    addr_chars[4] = 8'h80;
    send_address();
    make_hrp(2);
    compose_address(0, 20, 0, 0, 0);
    addr_chars[5] = "b";
    send_address();
    make_hrp(2);
    compose_address(1, 20, 0, 0, 0);
    addr_chars.insert(6, DELIM_CHAR);
    send_address();
    addr_chars.delete();
    addr_chars.insert(addr_chars.size(), 8'hff);
    send_address();
    make_hrp(20);
    addr_chars = hrp;
    send_address();
  endtask

  task automatic test_length_limits();
    addr_chars.delete();
    addr_chars.insert(addr_chars.size(), DELIM_CHAR);
    send_address();
    make_hrp(3);
    compose_address(-1, 0, 0, 0, 0);
    send_address();
    make_hrp(3);
    compose_address(0, 0, 0, 0, 0);
    send_address();
    make_hrp(1);
    compose_address(0, PROG_LIMIT, 0, 0, 0);
    send_address();
    hrp.delete();
    compose_address(0, PROG_LIMIT + 1, 0, 0, 0);
    send_address();
    fill_random_chars(COUNT_SAT + 3, 127);
    send_address();
  endtask

  task automatic test_checksum_and_padding();
    make_hrp(2);
    compose_address(0, 20, 0, 0, 1);
    send_address();
    make_hrp(2);
    compose_address(1, 20, 0, 0, 1);
    send_address();
    make_hrp(2);
    compose_address(0, 1, 0, 1, 0);
    send_address();
    make_hrp(2);
    compose_address(0, 5, 0, 1, 0);
    send_address();
    make_hrp(4);
    compose_address(0, 20, 0, 0, 0);
    addr_chars[8] = (addr_chars[8] == "q") ? "p" : "q";
    send_address();
  endtask

  task automatic test_backpressure();
    int k;
    idle_on = 0;
    hold_request = 1;
    for (k = 0; k < 4; k++) begin
      make_hrp(2);
      compose_address(0, 40, 0, 0, 0);
      send_address();
    end
  endtask

  task automatic test_random_addresses();
    int sent;
    int hl;
    int nb;
    int maxb;
    int ver;
    int k;
    int cm;
    sent = 0;
    while (sent < 500) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 5) begin
        fill_random_chars($urandom_range(1, 15), 255);
      end else begin
        hl = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 4) : $urandom_range(5, 20);
        make_hrp(hl);
        nb = ($urandom_range(0, 6) != 0) ? $urandom_range(1, 12) : $urandom_range(13, PROG_LIMIT);
        maxb = ((MAX_CHARS - 8 - hl) * 5) / 8;
        if (nb > maxb && $urandom_range(0, 9) != 0) nb = maxb;
        k = $urandom_range(0, 9);
        ver = (k < 6) ? 0 : (k < 9) ? $urandom_range(1, MAX_VERSION) : $urandom_range(17, 31);
        k = $urandom_range(0, 9);
        cm = (k < 6) ? 0 : (k < 8) ? 1 : 2;
        compose_address(ver, nb, cm, $urandom_range(0, 99) < 5, $urandom_range(0, 99) < 5);
        if ($urandom_range(0, 99) < 20) mangle_address();
      end
      sent += addr_chars.size();
      send_address();
    end
  endtask

  initial begin
    int gap;
    script_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        script_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_request = 0;
      end
      script_bus.ready <= 1'b1;
      repeat (idle_on ? $urandom_range(1, 8) : 1) @(posedge clk_i);
      gap = idle_gap();
      if (gap > 0) begin
        script_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_script
    script_res_t want;
    if (rst_ni && script_bus.valid && script_bus.ready) begin
      if (pending_script.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %02h accepted %b run_end %b",
                 $time, script_bus.script_byte, script_bus.accepted, script_bus.run_end);
        error_count++;
      end else begin
        want = pending_script.pop_front();
        if (script_bus.script_byte !== want.sbyte) begin
          $display("%0t: script_byte expected %02h actual %02h",
                   $time, want.sbyte, script_bus.script_byte);
          error_count++;
        end
        if (script_bus.accepted !== want.accepted) begin
          $display("%0t: accepted expected %b actual %b",
                   $time, want.accepted, script_bus.accepted);
          error_count++;
        end
        if (script_bus.run_end !== want.run_end) begin
          $display("%0t: run_end expected %b actual %b",
                   $time, want.run_end, script_bus.run_end);
          error_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    error_count = 0;
    idle_on = 0;
    hold_request = 0;
    clear_decoder();
    rst_ni              <= 1'b0;
    char_bus.valid      <= 1'b0;
    char_bus.char_code  <= 8'd0;
    char_bus.final_char <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_segwit_basics();
    test_version_range();
    test_bad_characters();
    test_length_limits();
    test_checksum_and_padding();
    test_backpressure();
    test_random_addresses();
    char_bus.valid <= 1'b0;
    while (pending_script.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
src/bech_pkg.sv
src/bech_if.sv
src/bech_ctrl.sv
src/bech_dp.sv
src/bech32_address_decoder_unit.sv
src/bech_chk.sv
verif/testbench.sv
